FILE: rtl/core/bvs_pkg.sv
// Shared types and codes for the bounded vector store core.
// Used by bvs_ctrl, bvs_datapath and bounded_vector_store_core; no dependencies.
package bvs_pkg;

  // Request kinds carried on req_type.
  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_INSERT = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Source of the result data word.
  localparam logic [1:0] DSEL_ZERO  = 2'd0;
  localparam logic [1:0] DSEL_RDATA = 2'd1;
  localparam logic [1:0] DSEL_ONES  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;         // capture the accepted request word
    logic       push_wr;      // write value at count, count up
    logic       rd_top;       // read last entry, count down
    logic       rd_idx;       // read entry at index
    logic       ptr_load;     // walk pointer takes the count
    logic       shift_step;   // read entry below pointer, write back pending entry
    logic       shift_flush;  // write the last pending entry of a shift
    logic       fill_step;    // write zero at pointer, pointer up
    logic       put;          // write value at index
    logic       cnt_inc;      // count up by one
    logic       cnt_set_idx;  // count becomes index plus one
    logic       resp;         // issue the result word
    logic [1:0] resp_status;
    logic [1:0] resp_dsel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       empty;
    logic       full;
    logic       idx_lt_cnt;
    logic       idx_ge_depth;
    logic       ptr_gt_idx;
    logic       ptr_lt_idx;
  } flags_t;

endpackage

FILE: rtl/core/bvs_datapath.sv
// Datapath of the bounded vector store: element memory, count, walk pointer
// and result registers. Depends on bvs_pkg for the command and flag types.
module bvs_datapath #(
  parameter int DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  bvs_pkg::cmd_t       cmd,
  output bvs_pkg::flags_t     flags,
  input  logic [1:0]          req_type,
  input  logic [9:0]          index,
  input  logic signed [31:0]  value,
  output logic                done,
  output logic [1:0]          status,
  output logic signed [31:0]  data,
  output logic [10:0]         count
);
  import bvs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > 11) ? CW : 11;
  localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

  logic [31:0]    mem [DEPTH];
  logic [31:0]    rdata;
  logic [1:0]     kind;
  logic [9:0]     idx;
  logic [31:0]    word;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  cnt_next;
  logic [CW-1:0]  ptr;
  logic [CW-1:0]  ptr_next;
  logic           pend;
  logic [CW-1:0]  cnt_inc1;
  logic [CW-1:0]  cnt_dec1;
  logic [CW-1:0]  ptr_inc1;
  logic [CW-1:0]  ptr_dec1;
  logic [WW-1:0]  idx_w;
  logic [WW-1:0]  cnt_w;
  logic [WW-1:0]  ptr_w;
  logic [WW-1:0]  idx_inc1;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [31:0]    wr_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;

  assign cnt_inc1 = cnt + CW'(1);
  assign cnt_dec1 = cnt - CW'(1);
  assign ptr_inc1 = ptr + CW'(1);
  assign ptr_dec1 = ptr - CW'(1);
  assign idx_w    = WW'(idx);
  assign cnt_w    = WW'(cnt);
  assign ptr_w    = WW'(ptr);
  assign idx_inc1 = idx_w + WW'(1);

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= req_type;
      idx  <= index;
      word <= value;
    end
  end

  // Decision flags for the controller.
  always_comb begin
    flags.kind         = kind;
    flags.empty        = (cnt == '0);
    flags.full         = (cnt_w >= DEPTH_W);
    flags.idx_lt_cnt   = (idx_w < cnt_w);
    flags.idx_ge_depth = (idx_w >= DEPTH_W);
    flags.ptr_gt_idx   = (ptr_w > idx_w);
    flags.ptr_lt_idx   = (ptr_w < idx_w);
  end

  // Write port selection: one write per cycle at most.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt[AW-1:0];
    wr_data = word;
    if (cmd.push_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt[AW-1:0];
      wr_data = word;
    end else if ((cmd.shift_step && pend) || cmd.shift_flush) begin
      wr_en   = 1'b1;
      wr_addr = ptr_inc1[AW-1:0];
      wr_data = rdata;
    end else if (cmd.fill_step) begin
      wr_en   = 1'b1;
      wr_addr = ptr[AW-1:0];
      wr_data = '0;
    end else if (cmd.put) begin
      wr_en   = 1'b1;
      wr_addr = idx_w[AW-1:0];
      wr_data = word;
    end
  end

  // Read port selection.
  always_comb begin
    rd_en   = cmd.rd_top || cmd.rd_idx || cmd.shift_step;
    rd_addr = idx_w[AW-1:0];
    if (cmd.rd_top) begin
      rd_addr = cnt_dec1[AW-1:0];
    end else if (cmd.shift_step) begin
      rd_addr = ptr_dec1[AW-1:0];
    end
  end

  // Element memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Count and walk pointer updates.
  always_comb begin
    cnt_next = cnt;
    if (cmd.push_wr || cmd.cnt_inc) begin
      cnt_next = cnt_inc1;
    end else if (cmd.rd_top) begin
      cnt_next = cnt_dec1;
    end else if (cmd.cnt_set_idx) begin
      cnt_next = idx_inc1[CW-1:0];
    end
    ptr_next = ptr;
    if (cmd.ptr_load) begin
      ptr_next = cnt;
    end else if (cmd.shift_step) begin
      ptr_next = ptr_dec1;
    end else if (cmd.fill_step) begin
      ptr_next = ptr_inc1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
      ptr  <= '0;
    end else begin
      cnt <= cnt_next;
      ptr <= ptr_next;
      if (cmd.ptr_load) begin
        pend <= 1'b0;
      end else if (cmd.shift_step) begin
        pend <= 1'b1;
      end
    end
  end

  // Result word registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      status <= cmd.resp_status;
      case (cmd.resp_dsel)
        DSEL_RDATA: data <= rdata;
        DSEL_ONES:  data <= '1;
        default:    data <= '0;
      endcase
    end
  end

  assign count = cnt_w[10:0];

  // The count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt_w <= DEPTH_W)
    else $error("element count above depth");

  // A bad result (empty pop or bad index) always carries minus one.
  a_bad_data: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_BAD) |-> data == -32'sd1)
    else $error("bad index result without minus one");

  // A shift step only runs above the target index.
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_step |-> ptr_w > idx_w)
    else $error("shift step at or below index");

  // The count moves only when a command asks for it.
  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push_wr || cmd.cnt_inc || cmd.rd_top || cmd.cnt_set_idx) |=> $stable(cnt))
    else $error("count changed without a command");

endmodule

FILE: rtl/core/bvs_ctrl.sv
// Controller state machine of the bounded vector store.
// Depends on bvs_pkg for command, flag and code definitions.
module bvs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  bvs_pkg::flags_t  flags,
  output bvs_pkg::cmd_t    cmd
);
  import bvs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  // Next state and command decode.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        case (flags.kind)
          REQ_PUSH: begin
            cmd.resp      = 1'b1;
            cmd.resp_dsel = DSEL_ZERO;
            if (flags.full) begin
              cmd.resp_status = ST_FULL;
            end else begin
              cmd.push_wr     = 1'b1;
              cmd.resp_status = ST_OK;
            end
          end
          REQ_POP: begin
            if (flags.empty) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = ST_BAD;
              cmd.resp_dsel   = DSEL_ONES;
            end else begin
              cmd.rd_top = 1'b1;
              state_next = S_RDWAIT;
            end
          end
          REQ_READ: begin
            if (!flags.idx_lt_cnt) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = ST_BAD;
              cmd.resp_dsel   = DSEL_ONES;
            end else begin
              cmd.rd_idx = 1'b1;
              state_next = S_RDWAIT;
            end
          end
          default: begin
            if (flags.idx_lt_cnt ? flags.full : flags.idx_ge_depth) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = ST_FULL;
              cmd.resp_dsel   = DSEL_ZERO;
            end else begin
              cmd.ptr_load = 1'b1;
              state_next   = flags.idx_lt_cnt ? S_SHIFT : S_FILL;
            end
          end
        endcase
      end
      S_RDWAIT: begin
        cmd.resp        = 1'b1;
        cmd.resp_status = ST_OK;
        cmd.resp_dsel   = DSEL_RDATA;
        state_next      = S_IDLE;
      end
      S_SHIFT: begin
        // Move entries up one place, top first, until the pointer meets the index.
        if (flags.ptr_gt_idx) begin
          cmd.shift_step = 1'b1;
        end else begin
          cmd.shift_flush = 1'b1;
          state_next      = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put         = 1'b1;
        cmd.cnt_inc     = 1'b1;
        cmd.resp        = 1'b1;
        cmd.resp_status = ST_OK;
        cmd.resp_dsel   = DSEL_ZERO;
        state_next      = S_IDLE;
      end
      S_FILL: begin
        // Zero the gap between the count and the index, then place the word.
        if (flags.ptr_lt_idx) begin
          cmd.fill_step = 1'b1;
        end else begin
          cmd.put         = 1'b1;
          cmd.cnt_set_idx = 1'b1;
          cmd.resp        = 1'b1;
          cmd.resp_status = ST_OK;
          cmd.resp_dsel   = DSEL_ZERO;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // An accepted word always moves the machine out of idle.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == S_DECIDE)
    else $error("accepted word not decoded");

  // Issuing a result always ends the request.
  a_resp_end: assert property (@(posedge clk) disable iff (rst)
    cmd.resp |=> state == S_IDLE)
    else $error("result issued before request end");

  // Only one memory write source is active in a cycle.
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push_wr, cmd.shift_flush, cmd.fill_step, cmd.put}))
    else $error("more than one write command");

endmodule

FILE: rtl/core/bounded_vector_store_core.sv
// Top level of the bounded vector store: a fixed-depth array of signed words
// with an element count. Instantiates bvs_ctrl and bvs_datapath; uses bvs_pkg.
//
//   Channel   Signals                          Handshake
//   request   req_type, index, value           taken when start && !busy
//   result    status, data, count              valid for one cycle while done
//
// Push and any rejected request get their result from the decide state;
// pop and read (memory read) get it from the read-wait state after that.
// Insert below the count walks the shift state, one memory entry moved per
// cycle through the single read and write port, then the put state; insert
// past the count walks the fill state, one zero written per cycle.
// A new request may be taken in the cycle that done is high.
// Synchronous reset empties the array; the memory needs no clearing.
module bounded_vector_store_core #(
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [9:0]         index,
  input  logic signed [31:0] value,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] data,
  output logic [10:0]        count
);
  import bvs_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  // Sequencing of each request.
  bvs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .flags (flags),
    .cmd   (cmd)
  );

  // Storage, count and result registers.
  bvs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .flags    (flags),
    .req_type (req_type),
    .index    (index),
    .value    (value),
    .done     (done),
    .status   (status),
    .data     (data),
    .count    (count)
  );

endmodule

FILE: dv/bvs_store_checker.sv
// Checker for the bounded vector store core: predicts every result word and compares it.
// Uses the request and result codes from bvs_pkg; instantiated next to the block.
module bvs_store_checker
  import bvs_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         req_type,
  input  logic [9:0]         index,
  input  logic signed [31:0] value,
  input  logic               done,
  input  logic [1:0]         status,
  input  logic signed [31:0] data,
  input  logic [10:0]        count,
  output int                 failures,
  output int                 outstanding,
  output logic [10:0]        model_count,
  output int                 n_requests,
  output int                 n_empty,
  output int                 n_full,
  output int                 peak_count
);

  // One expected result word.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic [10:0] count;
  } outcome_t;

  // Shadow copy of the array and its element count.
  logic [31:0] shadow_mem [DEPTH];
  logic [10:0] shadow_count;
  outcome_t    expected_q [$];
  int          n_results;

  assign model_count = shadow_count;

  // Apply one request word to the shadow array and return the result it gives.
  function automatic outcome_t apply_request(logic [1:0] kind, logic [9:0] pos,
                                             logic [31:0] word);
    outcome_t r;
    int       i;
    r.status = ST_OK;
    r.data = '0;
    case (kind)
      REQ_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_mem[shadow_count] = word;
          shadow_count++;
        end
      end
      REQ_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_BAD;
          r.data = '1;
        end else begin
          shadow_count--;
          r.data = shadow_mem[shadow_count];
        end
      end
      REQ_READ: begin
        if (pos >= shadow_count) begin
          r.status = ST_BAD;
          r.data = '1;
        end else begin
          r.data = shadow_mem[pos];
        end
      end
      default: begin
        // Below the count the tail moves up one place; at or past it the gap gets zeros.
        if (pos < shadow_count) begin
          if (shadow_count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = shadow_count; i > pos; i--) shadow_mem[i] = shadow_mem[i-1];
            shadow_mem[pos] = word;
            shadow_count++;
          end
        end else if (pos >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_count; i < pos; i++) shadow_mem[i] = '0;
          shadow_mem[pos] = word;
          shadow_count = 11'(pos) + 11'd1;
        end
      end
    endcase
    r.count = shadow_count;
    return r;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    failures++;
  endtask

  // Results are checked before new requests are taken, so a result that meets an
  // empty queue in the same cycle as a request is still flagged.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      shadow_count = '0;
      expected_q.delete();
      failures = 0;
      outstanding = 0;
      n_requests = 0;
      n_empty = 0;
      n_full = 0;
      n_results = 0;
      peak_count = 0;
    end else begin
      if (done) begin
        n_results++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                    n_results));
        end else begin
          want = expected_q.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      n_results, status, want.status));
          if (data !== want.data)
            report_mismatch($sformatf("result %0d data %h, expected %h",
                                      n_results, data, want.data));
          if (count !== want.count)
            report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                      n_results, count, want.count));
        end
      end
      if (start && !busy) begin
        want = apply_request(req_type, index, value);
        expected_q.push_back(want);
        n_requests++;
        if (want.status == ST_BAD) n_empty++;
        if (want.status == ST_FULL) n_full++;
        if (want.count > peak_count) peak_count = want.count;
      end
      outstanding = expected_q.size();
    end
  end

endmodule

FILE: dv/bounded_vector_store_core_tb.sv
// Testbench top for the bounded vector store core: clock, reset, request stimulus and verdict.
// Depends on bvs_pkg, bounded_vector_store_core and bvs_store_checker.
module bounded_vector_store_core_tb;
  import bvs_pkg::*;

  localparam int DEPTH = 1024;
  localparam int STALL_LIMIT = 8192;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         req_type = '0;
  logic [9:0]         index = '0;
  logic signed [31:0] value = '0;
  logic               busy;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic [10:0]        count;

  int          failures;
  int          outstanding;
  logic [10:0] model_count;
  int          n_requests;
  int          n_empty;
  int          n_full;
  int          peak_count;
  int          idle_pct = 0;
  int          stall_cycles = 0;

  bounded_vector_store_core #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .index(index), .value(value),
    .done(done), .status(status), .data(data), .count(count)
  );

  bvs_store_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .index(index), .value(value),
    .done(done), .status(status), .data(data), .count(count),
    .failures(failures), .outstanding(outstanding), .model_count(model_count),
    .n_requests(n_requests), .n_empty(n_empty), .n_full(n_full),
    .peak_count(peak_count)
  );

  always #1 clk = ~clk;

  // End the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one request word, with a random gap first, and return at the falling edge
  // after the edge that took it.
  task automatic send_request(input logic [1:0] kind, input logic [9:0] pos,
                              input logic [31:0] word);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    req_type <= kind;
    index <= pos;
    value <= word;
    // Busy only moves at a rising edge, so it is steady at the falling edge.
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  // Hold requests off until every expected result word has come back.
  task automatic drain;
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Random requests. Away from the top, pops win once the array grows, so shifts and
  // gap fills stay short; near the top, indexes stay close to the count.
  task automatic run_random(input int items, input bit near_top);
    logic [1:0]  kind;
    logic [9:0]  pos;
    logic [31:0] word;
    int          cnt;
    int          pop_weight;
    int          roll;
    int          hi;
    int          lo;
    for (int n = 0; n < items; n++) begin
      cnt = int'(model_count);
      pop_weight = near_top ? 30 : (cnt > 40 ? 45 : 20);
      roll = $urandom_range(99);
      if (roll < pop_weight) kind = REQ_POP;
      else if (roll < pop_weight + 25) kind = REQ_PUSH;
      else if (roll < pop_weight + 50) kind = REQ_READ;
      else kind = REQ_INSERT;
      hi = (cnt + 4 > DEPTH - 1) ? DEPTH - 1 : cnt + 4;
      lo = (near_top && cnt > 16) ? cnt - 16 : 0;
      if (lo > hi) lo = hi;
      if (kind == REQ_READ && $urandom_range(4) == 0) pos = 10'($urandom);
      else pos = 10'($urandom_range(hi, lo));
      case ($urandom_range(15))
        0: word = 32'h7FFF_FFFF;
        1: word = 32'h8000_0000;
        2: word = '1;
        3: word = '0;
        default: word = $urandom;
      endcase
      send_request(kind, pos, word);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty array, extreme words, shifts, set at the count and a zero-filled gap.
    idle_pct = 7;
    send_request(REQ_POP, 10'd0, 32'd0);
    send_request(REQ_READ, 10'd0, 32'd0);
    send_request(REQ_READ, 10'd1023, 32'd0);
    send_request(REQ_PUSH, 10'd0, 32'h7FFF_FFFF);
    send_request(REQ_PUSH, 10'd1023, 32'h8000_0000);
    send_request(REQ_PUSH, 10'd0, 32'hFFFF_FFFF);
    send_request(REQ_PUSH, 10'd0, 32'h0000_0000);
    send_request(REQ_READ, 10'd0, 32'd0);
    send_request(REQ_READ, 10'd3, 32'd0);
    send_request(REQ_READ, 10'd4, 32'd0);
    send_request(REQ_INSERT, 10'd0, 32'h5555_5555);
    send_request(REQ_INSERT, 10'd2, 32'hAAAA_AAAA);
    send_request(REQ_INSERT, 10'd5, 32'h1234_5678);
    send_request(REQ_INSERT, 10'd7, 32'd1);
    send_request(REQ_INSERT, 10'd12, 32'hFFFF_FFFE);
    send_request(REQ_READ, 10'd9, 32'd0);
    send_request(REQ_READ, 10'd12, 32'd0);
    send_request(REQ_POP, 10'd0, 32'd0);
    send_request(REQ_POP, 10'd0, 32'd0);
    drain();

    // Random phases: light sender gaps, heavy sender gaps, then back to back.
    run_random(190, 1'b0);
    drain();
    idle_pct = 82;
    run_random(190, 1'b0);
    drain();
    idle_pct = 0;
    run_random(150, 1'b0);

    // Fill to capacity through one long gap fill, then work around the full array.
    send_request(REQ_INSERT, 10'd1023, $urandom);
    send_request(REQ_PUSH, 10'd0, 32'd5);
    send_request(REQ_INSERT, 10'd0, $urandom);
    send_request(REQ_INSERT, 10'd1023, $urandom);
    send_request(REQ_READ, 10'd1023, 32'd0);
    send_request(REQ_READ, 10'd0, 32'd0);
    send_request(REQ_POP, 10'd0, 32'd0);
    send_request(REQ_INSERT, 10'd1023, $urandom);
    send_request(REQ_POP, 10'd0, 32'd0);
    send_request(REQ_POP, 10'd0, 32'd0);
    send_request(REQ_INSERT, 10'd1020, $urandom);
    run_random(40, 1'b1);

    // Wait out the last results and any stray word after them.
    drain();
    repeat (1100) @(negedge clk);

    $display("Checked %0d requests over three gap patterns: %0d empty or bad index, %0d full.",
             n_requests, n_empty, n_full);
    $display("The element count peaked at %0d of %0d entries.", peak_count, DEPTH);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/bvs_pkg.sv
rtl/core/bvs_datapath.sv
rtl/core/bvs_ctrl.sv
rtl/core/bounded_vector_store_core.sv
dv/bvs_store_checker.sv
dv/bounded_vector_store_core_tb.sv
